>>> hdl/gaca_pkg.sv
// Shared constants, types and gamma tables for the contrast adjust block.
package gaca_pkg;

    localparam int FRAC_BITS = 8;
    localparam int LW        = FRAC_BITS + 8;     // linear value width
    localparam int DW        = 2 * LW;            // dividend and quotient width
    localparam int SW        = LW + 2;            // signed difference width
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [LW-1:0] LIN_FULL = LW'(255) << FRAC_BITS;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSFER   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ONLY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FACTOR     = 3'd4;

    typedef logic [255:0][LW-1:0] t_tab;

    localparam logic [63:0] Q30_ONE = 64'd1 << 30;

    function automatic logic [63:0] mul30(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] p;
        p = a * b;
        return p >> 30;
    endfunction

    function automatic logic [63:0] pow5(input logic [63:0] r);
        logic [63:0] r2;
        r2 = mul30(r, r);
        return mul30(mul30(r2, r2), r);
    endfunction

    function automatic logic [63:0] root5(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] c;
        r = 64'd0;
        for (int b = 30; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (c <= Q30_ONE) begin
                if (pow5(c) <= x) begin
                    r = c;
                end
            end
        end
        return r;
    endfunction

    function automatic logic [LW-1:0] q30_to_lin(input logic [63:0] p);
        logic [63:0] s;
        s = ((64'd255 * p) << FRAC_BITS) + (64'd1 << 29);
        return LW'(s >> 30);
    endfunction

    // Build the linearising table: power 2.2 when pw is set, else sRGB.
    function automatic t_tab build_tab(input logic pw);
        t_tab        tb;
        logic [63:0] t;
        logic [63:0] u;
        logic [63:0] u2;
        for (int c = 0; c < 256; c++) begin
            if (pw) begin
                t = (64'(c) << 30) / 64'd255;
                tb[c] = q30_to_lin(mul30(mul30(t, t), root5(t)));
            end else if (c <= 10) begin
                tb[c] = LW'((((64'(c) * 64'd100) << FRAC_BITS) + 64'd646) / 64'd1292);
            end else begin
                u  = ((64'(c) * 64'd1000 + 64'd14025) << 30) / 64'd269025;
                u2 = mul30(u, u);
                tb[c] = q30_to_lin(mul30(u2, root5(u2)));
            end
        end
        return tb;
    endfunction

    localparam t_tab TAB_SRGB = build_tab(1'b0);
    localparam t_tab TAB_POW  = build_tab(1'b1);

endpackage

>>> hdl/gaca_in_if.sv
// Pixel input channel: valid, ready and one three-channel item.
interface gaca_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic       frame_start;
    logic [7:0] chan_a;
    logic [7:0] chan_b;
    logic [7:0] chan_c;

    modport source (output valid, action, frame_start, chan_a, chan_b, chan_c, input ready);
    modport sink   (input valid, action, frame_start, chan_a, chan_b, chan_c, output ready);
endinterface

>>> hdl/gaca_out_if.sv
// Pixel output channel: valid, ready and one adjusted pixel.
interface gaca_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] res_a;
    logic [7:0] res_b;
    logic [7:0] res_c;

    modport source (output valid, res_a, res_b, res_c, input ready);
    modport sink   (input valid, res_a, res_b, res_c, output ready);
endinterface

>>> hdl/gamma_aware_contrast_adjust.sv
// Gamma-aware contrast adjust: linearise, rescale, clamp and re-gamma pixels.
//
// i_px carries pixels in with an action bit: measure folds the linear values
// into a running minimum and maximum, apply rescales and emits one pixel on
// o_px. Both channels transfer when valid and ready are high together.
// Configuration must be written through i_cfg_we / i_cfg_idx / i_cfg_data only
// while the block is idle; the block itself does not enforce this.
// A measure item is folded into the range when it transfers. An apply item
// runs each processed channel in turn through one shared datapath: a setup
// state, in automatic mode a DW-bit (32 at 8 fraction bits) restoring divider,
// a clamp state and an 8-step binary search of the gamma table. Manual mode,
// or automatic mode when the range gives zero, skips the divider. Three
// channels are processed, or one with first_only set; then the output
// register is loaded. No new item is accepted until then.
// Synchronous reset clears the configuration to its defaults, sets the
// minimum to 255.0 and the maximum to 0 and empties the output register.
// A stalled receiver holds the result in the output register; the block
// finishes its next pixel and then waits until that register is free.
module gamma_aware_contrast_adjust
    import gaca_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    gaca_in_if.sink              i_px,
    gaca_out_if.source           o_px,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_CLAMP = 3'd3;
    localparam logic [2:0] S_SRCH  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    localparam int CNT_W = $clog2(DW);

    logic [2:0]       r_state;
    logic             r_mode, r_transfer, r_first_only;
    logic [8:0]       r_offset;
    logic [15:0]      r_factor;
    logic [LW-1:0]    r_min, r_max;
    logic [2:0][7:0]  r_code;
    logic [2:0][7:0]  r_res;
    logic [1:0]       r_ch;
    logic [DW-1:0]    r_v;
    logic [DW-1:0]    r_quo;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_div;
    logic [CNT_W-1:0] r_cnt;
    logic [LW-1:0]    r_lvl;
    logic [7:0]       r_n;
    logic [2:0]       r_bit;
    logic             r_ovalid;
    logic [2:0][7:0]  r_out;

    t_tab             tab;
    logic             in_xfer;
    logic [LW-1:0]    lin_a, lin_b, lin_c;
    logic [LW-1:0]    n_min, n_max;

    // datapath signals for the current channel
    logic [LW-1:0]    lin;
    logic [SW-1:0]    off_ext, diff, num, den;
    logic [LW:0]      an;
    logic [LW:0]      ad;
    logic [LW+16:0]   prod;
    logic             auto_zero;
    logic [DW-1:0]    dvd;
    logic [DW:0]      n_rem_sh;
    logic [DW-1:0]    n_rem;
    logic [DW-1:0]    n_quo;
    logic [7:0]       cand;
    logic [7:0]       n_n;
    logic [1:0]       last_ch;
    logic             out_free;

    assign tab      = r_transfer ? TAB_POW : TAB_SRGB;
    assign i_px.ready = (r_state == S_IDLE);
    assign in_xfer  = i_px.valid && i_px.ready;
    assign out_free = !r_ovalid || o_px.ready;
    assign last_ch  = r_first_only ? 2'd0 : 2'd2;

    assign o_px.valid = r_ovalid;
    assign o_px.res_a = r_out[0];
    assign o_px.res_b = r_out[1];
    assign o_px.res_c = r_out[2];

    // measure: fold the processed channels into the running range
    always_comb begin
        lin_a = tab[i_px.chan_a];
        lin_b = tab[i_px.chan_b];
        lin_c = tab[i_px.chan_c];
        n_min = i_px.frame_start ? LIN_FULL : r_min;
        n_max = i_px.frame_start ? '0 : r_max;
        if (lin_a > n_max) n_max = lin_a;
        if (lin_a < n_min) n_min = lin_a;
        if (!r_first_only) begin
            if (lin_b > n_max) n_max = lin_b;
            if (lin_b < n_min) n_min = lin_b;
            if (lin_c > n_max) n_max = lin_c;
            if (lin_c < n_min) n_min = lin_c;
        end
    end

    always_comb begin
        lin       = tab[r_code[r_ch]];
        off_ext   = SW'(signed'(r_offset)) << FRAC_BITS;
        diff      = {2'b00, lin} - off_ext;
        prod      = diff[LW:0] * r_factor;
        num       = {2'b00, lin} - {2'b00, r_min};
        den       = {2'b00, r_max} - {2'b00, r_min};
        an        = num[SW-1] ? (LW+1)'(-num) : num[LW:0];
        ad        = den[SW-1] ? (LW+1)'(-den) : den[LW:0];
        auto_zero = (den == '0) || (num == '0) || (num[SW-1] != den[SW-1]);
        dvd       = DW'({an, 8'b0} - {8'b0, an}) << FRAC_BITS;
        n_rem_sh  = {r_rem, r_quo[DW-1]};
        if (n_rem_sh >= {1'b0, r_div}) begin
            n_rem = DW'(n_rem_sh - {1'b0, r_div});
            n_quo = {r_quo[DW-2:0], 1'b1};
        end else begin
            n_rem = n_rem_sh[DW-1:0];
            n_quo = {r_quo[DW-2:0], 1'b0};
        end
        cand = r_n | (8'd1 << r_bit);
        n_n  = (tab[cand] <= r_lvl) ? cand : r_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_mode       <= 1'b0;
            r_transfer   <= 1'b0;
            r_first_only <= 1'b0;
            r_offset     <= '0;
            r_factor     <= 16'd256;
            r_min        <= LIN_FULL;
            r_max        <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MODE:       r_mode       <= i_cfg_data[0];
                    CFG_TRANSFER:   r_transfer   <= i_cfg_data[0];
                    CFG_FIRST_ONLY: r_first_only <= i_cfg_data[0];
                    CFG_OFFSET:     r_offset     <= i_cfg_data[8:0];
                    CFG_FACTOR:     r_factor     <= i_cfg_data;
                    default: ;
                endcase
            end
            // S_DONE reloads the output register itself
            if (r_ovalid && o_px.ready && r_state != S_DONE) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_code <= {i_px.chan_c, i_px.chan_b, i_px.chan_a};
                        r_ch   <= 2'd0;
                        if (i_px.action) begin
                            r_state <= S_PREP;
                        end else begin
                            r_min <= n_min;
                            r_max <= n_max;
                        end
                    end
                end
                S_PREP: begin
                    if (!r_mode) begin
                        // non-positive difference gives zero
                        if (!diff[SW-1] && diff != '0) begin
                            r_v <= DW'(prod >> 8);
                        end else begin
                            r_v <= '0;
                        end
                        r_state <= S_CLAMP;
                    end else if (auto_zero) begin
                        r_v     <= '0;
                        r_state <= S_CLAMP;
                    end else begin
                        r_rem   <= '0;
                        r_quo   <= dvd;
                        r_div   <= DW'(ad);
                        r_cnt   <= CNT_W'(DW - 1);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= n_rem;
                    r_quo <= n_quo;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_v     <= n_quo;
                        r_state <= S_CLAMP;
                    end
                end
                S_CLAMP: begin
                    r_lvl   <= (r_v > DW'(LIN_FULL)) ? LIN_FULL : r_v[LW-1:0];
                    r_n     <= 8'd0;
                    r_bit   <= 3'd7;
                    r_state <= S_SRCH;
                end
                S_SRCH: begin
                    r_n   <= n_n;
                    r_bit <= r_bit - 1'b1;
                    if (r_bit == 3'd0) begin
                        r_res[r_ch] <= n_n;
                        if (r_ch == last_ch) begin
                            r_state <= S_DONE;
                        end else begin
                            r_ch    <= r_ch + 1'b1;
                            r_state <= S_PREP;
                        end
                    end
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (out_free) begin
                        r_out[0] <= r_res[0];
                        r_out[1] <= r_first_only ? r_code[1] : r_res[1];
                        r_out[2] <= r_first_only ? r_code[2] : r_res[2];
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> bench/gaca_checker.sv
// Watches the pixel channels and the register port, predicts and compares results.
module gaca_checker
    import gaca_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    gaca_in_if                   i_px,
    gaca_out_if                  i_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_errors,
    output int                   o_waiting,
    output int                   o_applies,
    output int                   o_measures
);

    localparam bit ACT_MEASURE = 1'b0;
    localparam bit MODE_AUTO   = 1'b1;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
    } t_pixel;

    logic [LW-1:0] curve_srgb [256];
    logic [LW-1:0] curve_pow  [256];
    t_pixel        pixels_due [$];

    logic          cf_auto, cf_pow, cf_first;
    int            cf_offset;
    longint        cf_factor;
    logic [LW-1:0] lvl_min, lvl_max;

    function automatic longint unsigned qmul(longint unsigned x, longint unsigned y);
        return (x * y) >> 30;
    endfunction

    function automatic longint unsigned qfifth(longint unsigned r);
        longint unsigned sq;
        sq = qmul(r, r);
        return qmul(qmul(sq, sq), r);
    endfunction

    // Largest root whose truncated fifth power stays at or below x.
    function automatic longint unsigned qroot5(longint unsigned x);
        longint unsigned r, cand;
        r = 0;
        for (int b = 30; b >= 0; b--) begin
            cand = r | (64'd1 << b);
            if (cand <= (64'd1 << 30) && qfifth(cand) <= x) r = cand;
        end
        return r;
    endfunction

    function automatic logic [LW-1:0] qlin(longint unsigned p);
        return LW'(((255 * p * (64'd1 << FRAC_BITS)) + (64'd1 << 29)) >> 30);
    endfunction

    function automatic logic [7:0] regamma_code(logic [7:0] code);
        longint lin, v, num, den, diff;
        int n;
        lin = cf_pow ? curve_pow[code] : curve_srgb[code];
        v = 0;
        if (cf_auto != MODE_AUTO) begin
            diff = lin - longint'(cf_offset) * (64'd1 << FRAC_BITS);
            if (diff > 0) v = (diff * cf_factor) >>> 8;
        end else begin
            num = lin - longint'(lvl_min);
            den = longint'(lvl_max) - longint'(lvl_min);
            if (den != 0 && num != 0 && ((num > 0) == (den > 0))) begin
                if (num < 0) num = -num;
                if (den < 0) den = -den;
                v = (num * 255 * (64'd1 << FRAC_BITS)) / den;
            end
        end
        if (v > longint'(LIN_FULL)) v = LIN_FULL;
        n = 0;
        for (int k = 1; k < 256; k++)
            if (longint'(cf_pow ? curve_pow[k] : curve_srgb[k]) <= v) n++;
        return 8'(n);
    endfunction

    initial begin
        longint unsigned t, u, u2;
        for (int c = 0; c < 256; c++) begin
            t = (64'(c) << 30) / 255;
            curve_pow[c] = qlin(qmul(qmul(t, t), qroot5(t)));
            if (c <= 10) begin
                curve_srgb[c] = LW'(((64'(c) * 100 << FRAC_BITS) + 646) / 1292);
            end else begin
                u  = ((64'(c) * 1000 + 14025) << 30) / 269025;
                u2 = qmul(u, u);
                curve_srgb[c] = qlin(qmul(u2, qroot5(u2)));
            end
        end
    end

    assign o_waiting = pixels_due.size();

    always @(posedge i_clk) begin
        t_pixel       want, got;
        logic [7:0]   ch [3];
        logic [LW-1:0] l;
        int            nch;
        if (!i_rst_n) begin
            cf_auto <= 1'b0; cf_pow <= 1'b0; cf_first <= 1'b0;
            cf_offset <= 0; cf_factor <= 256;
            lvl_min <= LIN_FULL; lvl_max <= '0;
            o_errors <= 0; o_applies <= 0; o_measures <= 0;
            pixels_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MODE:       cf_auto <= i_cfg_data[0];
                    CFG_TRANSFER:   cf_pow <= i_cfg_data[0];
                    CFG_FIRST_ONLY: cf_first <= i_cfg_data[0];
                    CFG_OFFSET:     cf_offset <= int'($signed(i_cfg_data[8:0]));
                    CFG_FACTOR:     cf_factor <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_px.valid && i_px.ready) begin
                ch[0] = i_px.chan_a; ch[1] = i_px.chan_b; ch[2] = i_px.chan_c;
                nch = cf_first ? 1 : 3;
                if (i_px.action == ACT_MEASURE) begin
                    o_measures <= o_measures + 1;
                    // fold into the range seen so far, restarting on frame start
                    want.a = 0;
                    begin
                        logic [LW-1:0] mn, mx;
                        mn = i_px.frame_start ? LIN_FULL : lvl_min;
                        mx = i_px.frame_start ? '0 : lvl_max;
                        for (int i = 0; i < nch; i++) begin
                            l = cf_pow ? curve_pow[ch[i]] : curve_srgb[ch[i]];
                            if (l > mx) mx = l;
                            if (l < mn) mn = l;
                        end
                        lvl_min <= mn;
                        lvl_max <= mx;
                    end
                end else begin
                    o_applies <= o_applies + 1;
                    want.a = regamma_code(ch[0]);
                    want.b = cf_first ? ch[1] : regamma_code(ch[1]);
                    want.c = cf_first ? ch[2] : regamma_code(ch[2]);
                    pixels_due.push_back(want);
                end
            end
            if (i_res.valid && i_res.ready) begin
                got = '{i_res.res_a, i_res.res_b, i_res.res_c};
                if (pixels_due.size() == 0) begin
                    $display("%0t: result %h %h %h with none expected",
                             $realtime, got.a, got.b, got.c);
                    o_errors <= o_errors + 1;
                end else begin
                    want = pixels_due.pop_front();
                    if (got != want) begin
                        $display("%0t: pixel mismatch expected %h %h %h actual %h %h %h",
                                 $realtime, want.a, want.b, want.c, got.a, got.b, got.c);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

>>> bench/gamma_aware_contrast_adjust_tb.sv
// Stimulus, register writes and verdict for the contrast adjust block.
module gamma_aware_contrast_adjust_tb;
    import gaca_pkg::*;

    localparam bit ACT_MEASURE = 1'b0;
    localparam bit ACT_APPLY   = 1'b1;
    localparam int SETTLE      = 200;
    localparam int STALL_LIMIT = 20000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    int                   errors, waiting, n_apply, n_measure;
    int                   quiet = 0;
    bit                   no_gaps = 0;
    bit                   hold_req = 0;

    gaca_in_if  px_in();
    gaca_out_if px_out();

    gamma_aware_contrast_adjust uut (
        .i_clk, .i_rst_n, .i_px(px_in.sink), .o_px(px_out.source),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    gaca_checker chk (
        .i_clk, .i_rst_n, .i_px(px_in), .i_res(px_out),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_waiting(waiting),
        .o_applies(n_apply), .o_measures(n_measure)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        px_in.valid = 1'b0; px_in.action = 1'b0; px_in.frame_start = 1'b0;
        px_in.chan_a = '0; px_in.chan_b = '0; px_in.chan_c = '0;
        px_out.ready = 1'b0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver: random stalls, or one long hold-off on request.
    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                px_out.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_req = 0;
            end
            px_out.ready <= 1'b1;
            n = gap_len();
            if (n > 0) begin
                @(posedge i_clk);
                px_out.ready <= 1'b0;
                repeat (n - 1) @(posedge i_clk);
            end
        end
    end

    // Stall watchdog: no transfer on either side for too long ends the run.
    always @(posedge i_clk) begin
        if ((px_in.valid && px_in.ready) || (px_out.valid && px_out.ready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT) begin
            $display("** gamma_aware_contrast_adjust: FAILED **");
            $finish;
        end
    end

    task automatic send(bit act, bit fs, logic [7:0] a, logic [7:0] b, logic [7:0] c);
        int n;
        px_in.valid <= 1'b1;
        px_in.action <= act; px_in.frame_start <= fs;
        px_in.chan_a <= a; px_in.chan_b <= b; px_in.chan_c <= c;
        do @(posedge i_clk); while (!px_in.ready);
        n = gap_len();
        if (n > 0) begin
            px_in.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic settle();
        px_in.valid <= 1'b0;
        @(posedge i_clk);
        while (waiting != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic setup(bit m, bit tr, bit fo, int off, int fac);
        write_reg(CFG_MODE, CFG_W'(m));
        write_reg(CFG_TRANSFER, CFG_W'(tr));
        write_reg(CFG_FIRST_ONLY, CFG_W'(fo));
        write_reg(CFG_OFFSET, CFG_W'(off));
        write_reg(CFG_FACTOR, CFG_W'(fac));
    endtask

    function automatic logic [7:0] pick_code();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'd0;
        if (r == 1) return 8'd255;
        if (r == 2) return 8'($urandom_range(0, 12));
        return 8'($urandom);
    endfunction

    task automatic rnd_item(bit act, bit fs);
        send(act, fs, pick_code(), pick_code(), pick_code());
    endtask

    initial begin
        int off, fac, runs, sent;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: defaults, extremes, sRGB knee, empty range, first_only.
        send(ACT_APPLY, 1'b0, 8'd0, 8'd255, 8'd10);
        send(ACT_APPLY, 1'b1, 8'd11, 8'd128, 8'd1);
        settle();
        setup(1'b1, 1'b0, 1'b0, 0, 256);
        send(ACT_APPLY, 1'b0, 8'd0, 8'd255, 8'd77);
        send(ACT_MEASURE, 1'b1, 8'd40, 8'd40, 8'd40);
        send(ACT_APPLY, 1'b0, 8'd40, 8'd0, 8'd255);
        send(ACT_MEASURE, 1'b0, 8'd10, 8'd200, 8'd11);
        send(ACT_APPLY, 1'b0, 8'd10, 8'd200, 8'd100);
        send(ACT_MEASURE, 1'b1, 8'd0, 8'd255, 8'd128);
        send(ACT_APPLY, 1'b0, 8'd0, 8'd255, 8'd128);
        settle();
        setup(1'b0, 1'b1, 1'b1, -255, 16'hFF00);
        send(ACT_APPLY, 1'b0, 8'd0, 8'd255, 8'd170);
        send(ACT_APPLY, 1'b0, 8'd255, 8'd85, 8'd0);
        settle();
        setup(1'b0, 1'b0, 1'b0, 255, 1);
        send(ACT_APPLY, 1'b0, 8'd255, 8'd254, 8'd0);
        settle();
        write_reg(CFG_OFFSET, CFG_W'(-3));
        send(ACT_APPLY, 1'b0, 8'd255, 8'd3, 8'd0);
        settle();
        setup(1'b1, 1'b1, 1'b1, 0, 256);
        send(ACT_MEASURE, 1'b1, 8'd50, 8'd255, 8'd0);
        send(ACT_MEASURE, 1'b0, 8'd180, 8'd0, 8'd255);
        send(ACT_APPLY, 1'b0, 8'd100, 8'd170, 8'd85);
        send(ACT_APPLY, 1'b0, 8'd255, 8'd0, 8'd0);

        // Random phases: frames of measures then applies, with some noise.
        sent = 0;
        for (int ph = 0; sent < 850; ph++) begin
            settle();
            case (ph % 4)
                0: off = -255;
                1: off = 255;
                2: off = 0;
                default: off = $urandom_range(0, 510) - 255;
            endcase
            case ($urandom_range(0, 3))
                0: fac = 1;
                1: fac = 65280;
                2: fac = 256;
                default: fac = $urandom_range(1, 65280);
            endcase
            setup(1'($urandom), 1'($urandom), 1'($urandom), off, fac);
            no_gaps = (ph % 3 == 2);
            if (ph == 2) hold_req = 1;
            runs = $urandom_range(3, 6);
            for (int f = 0; f < runs; f++) begin
                if ($urandom_range(0, 9) == 0) begin
                    rnd_item(1'($urandom), 1'($urandom));
                    sent++;
                end
                rnd_item(ACT_MEASURE, $urandom_range(0, 7) != 0);
                sent++;
                repeat ($urandom_range(1, 8)) begin
                    rnd_item(ACT_MEASURE, 1'b0);
                    sent++;
                end
                repeat ($urandom_range(1, 10)) begin
                    rnd_item(ACT_APPLY, 1'($urandom));
                    sent++;
                end
            end
        end
        no_gaps = 0;
        settle();

        $display("Checked %0d adjusted pixels from %0d measure transfers over random settings.",
                 n_apply, n_measure);
        if (errors == 0) $display("** gamma_aware_contrast_adjust: PASSED **");
        else $display("** gamma_aware_contrast_adjust: FAILED **");
        $finish;
    end

endmodule

>>> files.f
hdl/gaca_pkg.sv
hdl/gaca_in_if.sv
hdl/gaca_out_if.sv
hdl/gamma_aware_contrast_adjust.sv
bench/gaca_checker.sv
bench/gamma_aware_contrast_adjust_tb.sv
